/* hw/rtl/crcdf_pkg.sv */
// Shared types, constants and the CRC-8 step function of the frame deframer.
`timescale 1ns / 1ps

package crcdf_pkg;

    localparam int DEFAULT_MAX_PAYLOAD = 32;
    localparam int LEN_W = 7;
    localparam int OUT_LEN_W = 6;
    localparam int CNT_W = 32;

    localparam logic [7:0] START_BYTE_RESET = 8'hA5;
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] good;
        logic [CNT_W-1:0] fail;
        logic [CNT_W-1:0] drop;
    } frame_cmd_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } mem_wr_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

/* hw/rtl/crcdf_cmd_queue.sv */
// Two-entry queue of frame commands between the parser and the result sequencer.
`timescale 1ns / 1ps

module crcdf_cmd_queue
    import crcdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_cmd_t push_cmd,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output frame_cmd_t head_cmd
);

    frame_cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hw/rtl/crcdf_front.sv */
// Frame parser: start byte hunt, length check, payload capture, CRC and counters.
`timescale 1ns / 1ps

module crcdf_front
    import crcdf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       q_full,
    output logic       push,
    output frame_cmd_t push_cmd,
    output mem_wr_t    mem_wr
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    logic [7:0]       start_reg;
    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       crc_reg, crc_next;
    logic             bank_reg, bank_next;
    logic [CNT_W-1:0] good_reg, good_next;
    logic [CNT_W-1:0] fail_reg, fail_next;
    logic [CNT_W-1:0] drop_reg, drop_next;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign rx_stall = q_full;
    assign accept = rx_valid && !q_full;

    always_comb
    begin
        phase_next = phase_reg;
        len_next = len_reg;
        cnt_next = cnt_reg;
        crc_next = crc_reg;
        bank_next = bank_reg;
        good_next = good_reg;
        fail_next = fail_reg;
        drop_next = drop_reg;
        push = 1'b0;
        mem_wr.en = 1'b0;
        mem_wr.bank = bank_reg;
        mem_wr.idx = cnt_reg;
        mem_wr.data = rx_byte;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        drop_next = drop_reg + CNT_W'(1);
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte == 8'd0 || rx_byte > 8'(MAX_PAYLOAD))
                    begin
                        drop_next = drop_reg + CNT_W'(1);
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        len_next = rx_byte[LEN_W-1:0];
                        cnt_next = '0;
                        crc_next = crc8_step(CRC_INIT, rx_byte);
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    mem_wr.en = 1'b1;
                    crc_next = crc8_step(crc_reg, rx_byte);
                    cnt_next = cnt_reg + LEN_W'(1);
                    if (cnt_next >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    if (crc_reg == rx_byte)
                    begin
                        good_next = good_reg + CNT_W'(1);
                    end
                    else
                    begin
                        fail_next = fail_reg + CNT_W'(1);
                    end
                    push = 1'b1;
                    bank_next = ~bank_reg;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        push_cmd.kind = (crc_reg == rx_byte) ? KIND_DATA : KIND_ERR;
        push_cmd.data = rx_byte;
        push_cmd.len = len_reg;
        push_cmd.good = good_next;
        push_cmd.fail = fail_next;
        push_cmd.drop = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_BYTE_RESET;
            phase_reg <= PH_HUNT;
            len_reg <= '0;
            cnt_reg <= '0;
            crc_reg <= CRC_INIT;
            bank_reg <= 1'b0;
            good_reg <= '0;
            fail_reg <= '0;
            drop_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                start_reg <= cfg_data;
            end
            phase_reg <= phase_next;
            len_reg <= len_next;
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
            bank_reg <= bank_next;
            good_reg <= good_next;
            fail_reg <= fail_next;
            drop_reg <= drop_next;
        end
    end

endmodule

/* hw/rtl/crcdf_back.sv */
// Result sequencer: payload buffer, readout of queued frames and output register.
`timescale 1ns / 1ps

module crcdf_back
    import crcdf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mem_wr_t              mem_wr,
    input  logic                 q_valid,
    input  frame_cmd_t           q_cmd,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic                 kind,
    output logic [7:0]           data_byte,
    output logic [OUT_LEN_W-1:0] frame_len,
    output logic                 last,
    output logic [CNT_W-1:0]     good_frames,
    output logic [CNT_W-1:0]     crc_fail_count,
    output logic [CNT_W-1:0]     sync_drop_count
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int MEM_DEPTH = 2 * (1 << IDX_W);

    localparam logic ST_FETCH = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    logic [7:0]       buf_mem [MEM_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             state_reg, state_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             bank_reg, bank_next;
    logic             res_valid_reg, res_valid_next;
    logic             out_free;
    logic             load;
    logic             load_kind;
    logic [7:0]       load_data;
    logic             load_last;
    logic             is_last;

    logic                 kind_reg;
    logic [7:0]           data_reg;
    logic [OUT_LEN_W-1:0] len_reg;
    logic                 last_reg;
    logic [CNT_W-1:0]     good_reg;
    logic [CNT_W-1:0]     fail_reg;
    logic [CNT_W-1:0]     drop_reg;

    assign out_free = !res_valid_reg || !res_stall;
    assign is_last = (idx_reg == (q_cmd.len - LEN_W'(1)));

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            buf_mem[{mem_wr.bank, mem_wr.idx[IDX_W-1:0]}] <= mem_wr.data;
        end
        rd_data_reg <= buf_mem[{bank_reg, idx_reg[IDX_W-1:0]}];
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        bank_next = bank_reg;
        pop = 1'b0;
        load = 1'b0;
        load_kind = KIND_DATA;
        load_data = rd_data_reg;
        load_last = 1'b0;
        case (state_reg)
            ST_FETCH:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == KIND_ERR)
                    begin
                        if (out_free)
                        begin
                            load = 1'b1;
                            load_kind = KIND_ERR;
                            load_data = q_cmd.data;
                            load_last = 1'b1;
                            pop = 1'b1;
                            bank_next = ~bank_reg;
                        end
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    load_last = is_last;
                    state_next = ST_FETCH;
                    if (is_last)
                    begin
                        pop = 1'b1;
                        idx_next = '0;
                        bank_next = ~bank_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + LEN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FETCH;
            idx_reg <= '0;
            bank_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            bank_reg <= bank_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= load_kind;
            data_reg <= load_data;
            len_reg <= q_cmd.len[OUT_LEN_W-1:0];
            last_reg <= load_last;
            good_reg <= q_cmd.good;
            fail_reg <= q_cmd.fail;
            drop_reg <= q_cmd.drop;
        end
    end

    assign res_valid = res_valid_reg;
    assign kind = kind_reg;
    assign data_byte = data_reg;
    assign frame_len = len_reg;
    assign last = last_reg;
    assign good_frames = good_reg;
    assign crc_fail_count = fail_reg;
    assign sync_drop_count = drop_reg;

endmodule

/* hw/rtl/crc8_frame_deframer_core.sv */
// Top level of the start/length/payload/CRC-8 frame deframer.
// Received bytes enter on rx_valid/rx_stall/rx_byte, one transfer per byte.
// The parser hunts for the start byte, then takes a length byte, the payload
// and a CRC-8 byte (polynomial 0x07, initial value zero) over length and payload.
// A good frame comes out on res_valid/res_stall as one transfer per payload
// byte with last on the final one; a bad CRC gives one error transfer.
// The user must write the start byte on cfg_valid/cfg_data only while the block
// is idle; the block itself does not enforce this. The parser takes one byte per
// cycle while rx_stall is low. Each payload result passes FETCH, then the registered
// buffer read and LOAD; an error result is loaded to the output register in FETCH.
// Two frame commands and two payload banks sit between parser and sequencer,
// so the parser runs ahead by up to one frame. When both slots are full,
// rx_stall is raised until the sequencer finishes a frame.
// A stalled result holds in the output register while the parser keeps going.
// Reset clears the counters, sets the start byte to 0xA5 and returns the
// parser to the hunt; no frame is pending afterward.
`timescale 1ns / 1ps

module crc8_frame_deframer_core
    import crcdf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    input  logic [7:0]           rx_byte,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic                 kind,
    output logic [7:0]           data_byte,
    output logic [OUT_LEN_W-1:0] frame_len,
    output logic                 last,
    output logic [CNT_W-1:0]     good_frames,
    output logic [CNT_W-1:0]     crc_fail_count,
    output logic [CNT_W-1:0]     sync_drop_count
);

    logic       q_full;
    logic       q_valid;
    logic       push;
    logic       pop;
    frame_cmd_t push_cmd;
    frame_cmd_t head_cmd;
    mem_wr_t    mem_wr;

    crcdf_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd),
        .mem_wr   (mem_wr)
    );

    crcdf_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .head_valid(q_valid),
        .head_cmd  (head_cmd)
    );

    crcdf_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .mem_wr         (mem_wr),
        .q_valid        (q_valid),
        .q_cmd          (head_cmd),
        .pop            (pop),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .kind           (kind),
        .data_byte      (data_byte),
        .frame_len      (frame_len),
        .last           (last),
        .good_frames    (good_frames),
        .crc_fail_count (crc_fail_count),
        .sync_drop_count(sync_drop_count)
    );

endmodule

/* test/tb_crc8_frame_deframer_core.sv */
// Self-checking testbench for the CRC-8 frame deframer with randomized frames and flow control.
`timescale 1ns / 1ps

module tb_crc8_frame_deframer_core;
    import crcdf_pkg::*;

    localparam int FRAME_MAX = DEFAULT_MAX_PAYLOAD;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        SEEK_SOF,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_CRC
    } parse_phase_e;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           data;
        logic [OUT_LEN_W-1:0] len;
        logic                 last;
        logic [CNT_W-1:0]     good;
        logic [CNT_W-1:0]     fail;
        logic [CNT_W-1:0]     drop;
    } frame_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_data = 8'h00;
    logic                 rx_valid = 1'b0;
    logic                 rx_stall;
    logic [7:0]           rx_byte = 8'h00;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic                 kind;
    logic [7:0]           data_byte;
    logic [OUT_LEN_W-1:0] frame_len;
    logic                 last;
    logic [CNT_W-1:0]     good_frames;
    logic [CNT_W-1:0]     crc_fail_count;
    logic [CNT_W-1:0]     sync_drop_count;

    logic [7:0]      rx_pending[$];
    frame_result_t   result_q[$];
    int              err_count = 0;
    int              gap_left = 0;
    int              stall_left = 0;
    bit              quiet = 1'b0;

    logic [7:0]       sof_cfg = START_BYTE_RESET;
    parse_phase_e     parse_phase = SEEK_SOF;
    logic [5:0]       want_len = '0;
    logic [5:0]       got_cnt = '0;
    logic [7:0]       crc_acc = CRC_INIT;
    logic [7:0]       body_store[0:FRAME_MAX-1];
    logic [CNT_W-1:0] ok_cnt = '0;
    logic [CNT_W-1:0] crc_err_cnt = '0;
    logic [CNT_W-1:0] drop_cnt = '0;

    crc8_frame_deframer_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .rx_valid        (rx_valid),
        .rx_stall        (rx_stall),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .kind            (kind),
        .data_byte       (data_byte),
        .frame_len       (frame_len),
        .last            (last),
        .good_frames     (good_frames),
        .crc_fail_count  (crc_fail_count),
        .sync_drop_count (sync_drop_count)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8)
        begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic string describe(input frame_result_t r);
        return $sformatf("kind=%0d data=%02h len=%0d last=%0d good=%0d fail=%0d drop=%0d",
                         r.kind, r.data, r.len, r.last, r.good, r.fail, r.drop);
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= REPORT_LIMIT)
        begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endtask

    // Advances the parser by one received byte and queues the results it releases.
    task automatic deframe_byte(input logic [7:0] b);
        frame_result_t r;
        case (parse_phase)
            SEEK_SOF:
            begin
                if (b == sof_cfg)
                begin
                    parse_phase = TAKE_LEN;
                end
                else
                begin
                    drop_cnt++;
                end
            end
            TAKE_LEN:
            begin
                if (b == 8'd0 || b > FRAME_MAX)
                begin
                    drop_cnt++;
                    parse_phase = SEEK_SOF;
                end
                else
                begin
                    want_len = b[5:0];
                    got_cnt = '0;
                    crc_acc = crc8_next(CRC_INIT, b);
                    parse_phase = TAKE_DATA;
                end
            end
            TAKE_DATA:
            begin
                if (got_cnt < FRAME_MAX)
                begin
                    body_store[got_cnt] = b;
                end
                crc_acc = crc8_next(crc_acc, b);
                got_cnt++;
                if (got_cnt >= want_len)
                begin
                    parse_phase = TAKE_CRC;
                end
            end
            default:
            begin
                if (crc_acc == b)
                begin
                    ok_cnt++;
                    for (int k = 0; k < want_len; k++)
                    begin
                        r = '{KIND_DATA, body_store[k], want_len, (k + 1 == want_len),
                              ok_cnt, crc_err_cnt, drop_cnt};
                        result_q.push_back(r);
                    end
                end
                else
                begin
                    crc_err_cnt++;
                    r = '{KIND_ERR, b, want_len, 1'b1, ok_cnt, crc_err_cnt, drop_cnt};
                    result_q.push_back(r);
                end
                parse_phase = SEEK_SOF;
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte <= 8'h00;
            gap_left = 0;
        end
        else
        begin
            if (rx_valid && !rx_stall)
            begin
                deframe_byte(rx_byte);
            end
            if (!rx_valid || !rx_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    rx_valid <= 1'b0;
                end
                else if (rx_pending.size() != 0 && !quiet && $urandom_range(0, 11) == 0)
                begin
                    gap_left = $urandom_range(0, 18);
                    rx_valid <= 1'b0;
                end
                else if (rx_pending.size() != 0)
                begin
                    rx_valid <= 1'b1;
                    rx_byte <= rx_pending.pop_front();
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (result_q.size() == 0)
                begin
                    note_error($sformatf("unexpected result: %s",
                        describe('{kind, data_byte, frame_len, last, good_frames,
                                   crc_fail_count, sync_drop_count})));
                end
                else if ({kind, data_byte, frame_len, last, good_frames, crc_fail_count,
                          sync_drop_count} !== result_q[0])
                begin
                    note_error($sformatf("mismatch: expected %s, got %s",
                        describe(result_q[0]),
                        describe('{kind, data_byte, frame_len, last, good_frames,
                                   crc_fail_count, sync_drop_count})));
                    void'(result_q.pop_front());
                end
                else
                begin
                    void'(result_q.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    task automatic push_frame(input logic [7:0] body[$], input bit bad_crc);
        logic [7:0] c;
        c = crc8_next(CRC_INIT, 8'(body.size()));
        rx_pending.push_back(sof_cfg);
        rx_pending.push_back(8'(body.size()));
        foreach (body[i])
        begin
            rx_pending.push_back(body[i]);
            c = crc8_next(c, body[i]);
        end
        if (bad_crc)
        begin
            c ^= 8'($urandom_range(1, 255));
        end
        rx_pending.push_back(c);
    endtask

    // Mostly well-formed frames with random content, some with a bad CRC, plus stray
    // bytes, bad lengths and frames cut short so that the parser loses alignment.
    task automatic fill_random(input int target);
        logic [7:0] body[$];
        int         used;
        int         sel;
        int         n;
        int         cut;
        used = 0;
        while (used < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                rx_pending.push_back(8'($urandom));
                used += 1;
            end
            else if (sel < 14)
            begin
                rx_pending.push_back(sof_cfg);
                rx_pending.push_back($urandom_range(0, 3) == 0 ? 8'd0 :
                                     8'($urandom_range(FRAME_MAX + 1, 255)));
                used += 2;
            end
            else if (sel < 17)
            begin
                n = $urandom_range(4, 12);
                cut = $urandom_range(0, n - 1);
                rx_pending.push_back(sof_cfg);
                rx_pending.push_back(8'(n));
                repeat (cut)
                begin
                    rx_pending.push_back(8'($urandom));
                end
                used += 2 + cut;
            end
            else
            begin
                n = (sel < 21) ? FRAME_MAX :
                    (sel < 40) ? $urandom_range(1, FRAME_MAX) : $urandom_range(1, 6);
                body = {};
                repeat (n)
                begin
                    body.push_back(8'($urandom));
                end
                push_frame(body, $urandom_range(0, 5) == 0);
                used += n + 3;
            end
        end
    endtask

    task automatic drain();
        while (rx_pending.size() != 0 || rx_valid)
        begin
            @(posedge clk);
        end
        while (result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_sof(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sof_cfg = v;
    endtask

    initial
    begin
        logic [7:0] body[$];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(sof_cfg);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(sof_cfg);
        rx_pending.push_back(8'(FRAME_MAX + 1));
        rx_pending.push_back(sof_cfg);
        rx_pending.push_back(sof_cfg);
        body = {8'h00};
        push_frame(body, 1'b0);
        body = {8'hFF, sof_cfg};
        push_frame(body, 1'b0);
        body = {8'h5A, 8'h3C, sof_cfg};
        push_frame(body, 1'b1);
        fill_random(30);
        drain();

        write_sof(8'h00);
        fill_random(80);
        drain();

        write_sof(8'hFF);
        fill_random(80);
        drain();

        write_sof(8'($urandom_range(1, 254)));
        fill_random(80);
        drain();

        write_sof(START_BYTE_RESET);
        quiet = 1'b1;
        fill_random(70);
        drain();
        repeat (20) @(posedge clk);

        err_count += result_q.size();
        if (err_count == 0)
        begin
            $display("tb_crc8_frame_deframer_core: clean");
        end
        else
        begin
            $display("tb_crc8_frame_deframer_core: errors");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("tb_crc8_frame_deframer_core: errors");
        $finish;
    end

endmodule
